// File: hdl/pfc_pkg.sv
package pfc_pkg;

  localparam int SYMS = 27;
  localparam int CELLS = 25;

  localparam logic [4:0] CELL_COUNT   = 5'd25;
  localparam logic [4:0] SHARED_SYM   = 5'd26;
  localparam logic [4:0] PAD_LETTER   = 5'd23;
  localparam logic [4:0] LAST_LETTER  = 5'd25;
  localparam logic [4:0] RESET_FIRST  = 5'd16;
  localparam logic [4:0] RESET_SECOND = 5'd25;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_SEAL = 2'd1;
  localparam logic [1:0] MODE_TEXT = 2'd2;
  localparam logic [1:0] MODE_END  = 2'd3;

  localparam logic CFG_MERGED_FIRST  = 1'b0;
  localparam logic CFG_MERGED_SECOND = 1'b1;

  typedef struct packed {
    logic key_append;
    logic seal_start;
    logic seal_step;
    logic set_pending;
    logic pend_lower_upd;
    logic clear_pending;
    logic pair_load;
    logic pair_a_in;
    logic pair_b_in;
    logic pos_read;
    logic tab_read;
    logic emit1;
    logic emit2;
    logic emit_dot;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_letter;
    logic is_dot;
    logic in_shared;
    logic same_letter;
    logic pending_valid;
    logic seal_done;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/pfc_dp.sv
module pfc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic [7:0]         in_char_in,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_char_out,
  output logic               out_last,
  input  pfc_pkg::ctrl_cmd_t cmd,
  output pfc_pkg::dp_status_t status
);

  logic [4:0] merged_first_r;
  logic [4:0] merged_second_r;

  logic [4:0] tab_mem [0:pfc_pkg::CELLS-1];
  logic [4:0] pos_mem [0:pfc_pkg::SYMS-1];
  logic [pfc_pkg::SYMS-1:0] present_r;
  logic [4:0] fill_r;
  logic [4:0] seal_cnt_r;

  logic       pend_valid_r;
  logic [4:0] pend_letter_r;
  logic       pend_lower_r;

  logic [4:0] a_letter_r;
  logic       a_lower_r;
  logic [4:0] b_letter_r;
  logic       b_lower_r;

  logic [4:0] pos1_r;
  logic [4:0] pos2_r;
  logic [4:0] tab1_r;
  logic [4:0] tab2_r;
  logic       xform_r;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic       in_upper;
  logic       in_lower;
  logic       in_is_letter;
  logic [7:0] in_offset;
  logic [4:0] in_letter;
  logic [4:0] s1;
  logic [4:0] s2;
  logic [4:0] app_sym;
  logic       app_en;
  logic [2:0] r1, c1, r2, c2;
  logic [2:0] qr1, qc1, qr2, qc2;
  logic [4:0] q1;
  logic [4:0] q2;
  logic       xform;
  logic       out_free;
  logic       out_load;
  logic [4:0] emit_sym;
  logic       emit_lower;
  logic [7:0] emit_char;

  function automatic logic [4:0] sym_of(input logic [4:0] l, input logic [4:0] m1,
                                        input logic [4:0] m2);
    if (l == m1 || l == m2) begin
      return pfc_pkg::SHARED_SYM;
    end
    return l;
  endfunction

  function automatic logic [2:0] row_of(input logic [4:0] p);
    if (p >= 5'd20) return 3'd4;
    if (p >= 5'd15) return 3'd3;
    if (p >= 5'd10) return 3'd2;
    if (p >= 5'd5)  return 3'd1;
    return 3'd0;
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p, input logic [2:0] r);
    logic [4:0] d;
    d = p - {r, 2'b00} - {2'b00, r};
    return d[2:0];
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // input decode
  assign in_upper = (in_char_in >= pfc_pkg::CHAR_UPPER_A) &&
                    (in_char_in <= pfc_pkg::CHAR_UPPER_Z);
  assign in_lower = (in_char_in >= pfc_pkg::CHAR_LOWER_A) &&
                    (in_char_in <= pfc_pkg::CHAR_LOWER_Z);
  assign in_is_letter = in_upper || in_lower;
  assign in_offset = in_char_in - (in_lower ? pfc_pkg::CHAR_LOWER_A : pfc_pkg::CHAR_UPPER_A);
  assign in_letter = in_offset[4:0];

  assign s1 = sym_of(a_letter_r, merged_first_r, merged_second_r);
  assign s2 = sym_of(b_letter_r, merged_first_r, merged_second_r);

  // table append
  assign app_sym = cmd.seal_step ? sym_of(seal_cnt_r, merged_first_r, merged_second_r)
                                 : sym_of(in_letter, merged_first_r, merged_second_r);
  assign app_en = (cmd.key_append || cmd.seal_step) && !present_r[app_sym] &&
                  (fill_r < pfc_pkg::CELL_COUNT);

  // digraph rules
  assign r1 = row_of(pos1_r);
  assign c1 = col_of(pos1_r, r1);
  assign r2 = row_of(pos2_r);
  assign c2 = col_of(pos2_r, r2);

  always_comb begin
    if (r1 == r2) begin
      qr1 = r1;
      qc1 = wrap_inc(c1);
      qr2 = r2;
      qc2 = wrap_inc(c2);
    end else if (c1 == c2) begin
      qr1 = wrap_inc(r1);
      qc1 = c1;
      qr2 = wrap_inc(r2);
      qc2 = c2;
    end else begin
      qr1 = r1;
      qc1 = c2;
      qr2 = r2;
      qc2 = c1;
    end
  end

  assign q1 = cell_of(qr1, qc1);
  assign q2 = cell_of(qr2, qc2);
  assign xform = present_r[s1] && present_r[s2] && (pos1_r != pos2_r);

  // result select
  assign out_free = !out_valid_r || out_ready;
  assign out_load = cmd.emit1 || cmd.emit2 || cmd.emit_dot;

  always_comb begin
    if (cmd.emit1) begin
      emit_sym   = xform_r ? tab1_r : s1;
      emit_lower = a_lower_r;
    end else begin
      emit_sym   = xform_r ? tab2_r : s2;
      emit_lower = b_lower_r;
    end
    if (cmd.emit_dot) begin
      emit_char = pfc_pkg::CHAR_DOT;
    end else if (emit_sym >= pfc_pkg::SHARED_SYM) begin
      emit_char = pfc_pkg::CHAR_STAR;
    end else begin
      emit_char = (emit_lower ? pfc_pkg::CHAR_LOWER_A : pfc_pkg::CHAR_UPPER_A) +
                  {3'b000, emit_sym};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merged_first_r  <= pfc_pkg::RESET_FIRST;
      merged_second_r <= pfc_pkg::RESET_SECOND;
    end else if (cfg_wr_en) begin
      if (cfg_index == pfc_pkg::CFG_MERGED_FIRST) begin
        merged_first_r <= cfg_data;
      end
      if (cfg_index == pfc_pkg::CFG_MERGED_SECOND) begin
        merged_second_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      fill_r     <= '0;
      seal_cnt_r <= '0;
    end else begin
      if (app_en) begin
        present_r[app_sym] <= 1'b1;
        fill_r             <= fill_r + 5'd1;
      end
      if (cmd.seal_start) begin
        seal_cnt_r <= '0;
      end else if (cmd.seal_step) begin
        seal_cnt_r <= seal_cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (app_en) begin
      tab_mem[fill_r]  <= app_sym;
      pos_mem[app_sym] <= fill_r;
    end
    if (cmd.pos_read) begin
      pos1_r <= pos_mem[s1];
      pos2_r <= pos_mem[s2];
    end
    if (cmd.tab_read) begin
      tab1_r  <= tab_mem[q1];
      tab2_r  <= tab_mem[q2];
      xform_r <= xform;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      pend_lower_r  <= 1'b0;
    end else if (cmd.clear_pending) begin
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      pend_lower_r  <= 1'b0;
    end else if (cmd.set_pending) begin
      pend_valid_r  <= 1'b1;
      pend_letter_r <= in_letter;
      pend_lower_r  <= in_lower;
    end else if (cmd.pend_lower_upd) begin
      pend_lower_r  <= in_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_load) begin
      a_letter_r <= cmd.pair_a_in ? in_letter : pend_letter_r;
      a_lower_r  <= cmd.pair_a_in ? in_lower  : pend_lower_r;
      b_letter_r <= cmd.pair_b_in ? in_letter : pfc_pkg::PAD_LETTER;
      b_lower_r  <= cmd.pair_b_in ? in_lower  : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= emit_char;
      out_last_r <= cmd.emit_dot || (cmd.emit2 && cmd.emit_last);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  assign status.is_letter     = in_is_letter;
  assign status.is_dot        = (in_char_in == pfc_pkg::CHAR_DOT);
  assign status.in_shared     = (sym_of(in_letter, merged_first_r, merged_second_r) ==
                                 pfc_pkg::SHARED_SYM);
  assign status.same_letter   = (in_letter == pend_letter_r);
  assign status.pending_valid = pend_valid_r;
  assign status.seal_done     = (seal_cnt_r == pfc_pkg::LAST_LETTER);
  assign status.out_free      = out_free;

endmodule

// File: hdl/pfc_ctrl.sv
module pfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  pfc_pkg::dp_status_t status,
  output pfc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SEAL  = 7'b0000010,
    ST_POS   = 7'b0000100,
    ST_TAB   = 7'b0001000,
    ST_EMIT1 = 7'b0010000,
    ST_EMIT2 = 7'b0100000,
    ST_DOT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   dot_r, dot_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    dot_nxt   = dot_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            pfc_pkg::MODE_KEY: begin
              cmd.key_append = status.is_letter;
            end
            pfc_pkg::MODE_SEAL: begin
              cmd.seal_start = 1'b1;
              state_nxt      = ST_SEAL;
            end
            pfc_pkg::MODE_TEXT: begin
              if (status.is_dot) begin
                if (status.pending_valid) begin
                  cmd.pair_load     = 1'b1;
                  cmd.clear_pending = 1'b1;
                  dot_nxt           = 1'b1;
                  state_nxt         = ST_POS;
                end else begin
                  state_nxt = ST_DOT;
                end
              end else if (status.is_letter) begin
                if (!status.pending_valid) begin
                  if (status.in_shared) begin
                    cmd.pair_load = 1'b1;
                    cmd.pair_a_in = 1'b1;
                    dot_nxt       = 1'b0;
                    state_nxt     = ST_POS;
                  end else begin
                    cmd.set_pending = 1'b1;
                  end
                end else if (status.same_letter) begin
                  cmd.pair_load      = 1'b1;
                  cmd.pend_lower_upd = 1'b1;
                  dot_nxt            = 1'b0;
                  state_nxt          = ST_POS;
                end else begin
                  cmd.pair_load     = 1'b1;
                  cmd.pair_b_in     = 1'b1;
                  cmd.clear_pending = 1'b1;
                  dot_nxt           = 1'b0;
                  state_nxt         = ST_POS;
                end
              end
            end
            pfc_pkg::MODE_END: begin
              if (status.pending_valid) begin
                cmd.pair_load     = 1'b1;
                cmd.clear_pending = 1'b1;
                dot_nxt           = 1'b0;
                state_nxt         = ST_POS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEAL: begin
        cmd.seal_step = 1'b1;
        if (status.seal_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POS: begin
        cmd.pos_read = 1'b1;
        state_nxt    = ST_TAB;
      end
      ST_TAB: begin
        cmd.tab_read = 1'b1;
        state_nxt    = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (status.out_free) begin
          cmd.emit1 = 1'b1;
          state_nxt = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        if (status.out_free) begin
          cmd.emit2     = 1'b1;
          cmd.emit_last = !dot_r;
          state_nxt     = dot_r ? ST_DOT : ST_IDLE;
        end
      end
      ST_DOT: begin
        if (status.out_free) begin
          cmd.emit_dot = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dot_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dot_r   <= dot_nxt;
    end
  end

endmodule

// File: hdl/playfair_digraph_cipher_top.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_mode[1:0], in_char_in[7:0]
// out       out_valid / out_ready  out_char_out[7:0], out_last
// cfg       cfg_wr_en              cfg_index[0:0], cfg_data[4:0]
//
// Key characters, skipped characters and a text letter that opens a pair are taken without leaving idle.
// Seal steps once per letter A..Z, appending each new symbol through the single write port.
// A pair passes through position read, table read and two results, each result waiting for a free output.
// A full stop adds the echoed '.' from its own state, after the padded pair when a letter is open.
// Reset is synchronous, active low; it clears the table and the open pair.
// A held result register stalls the pair sequencer; input is taken only when idle.
module playfair_digraph_cipher_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_last
);

  pfc_pkg::ctrl_cmd_t  cmd;
  pfc_pkg::dp_status_t status;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .status   (status),
    .cmd      (cmd)
  );

  pfc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_char_in   (in_char_in),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int GRID_SIDE = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam int CHUNK_ITEMS = 11;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cipher_char_t;

  class cipher_sb;
    logic [4:0]   merged_a;
    logic [4:0]   merged_b;
    logic [4:0]   cell_sym [pfc_pkg::CELLS];
    bit           sym_in_table [pfc_pkg::SYMS];
    logic [4:0]   sym_cell [pfc_pkg::SYMS];
    int           cells_used;
    bit           open_valid;
    logic [4:0]   open_letter;
    bit           open_lower;
    cipher_char_t ciphertext_q[$];
    cipher_char_t step_q[$];
    int           errors;

    function new();
      merged_a = pfc_pkg::RESET_FIRST;
      merged_b = pfc_pkg::RESET_SECOND;
      foreach (cell_sym[i]) cell_sym[i] = '0;
      foreach (sym_in_table[i]) begin
        sym_in_table[i] = 1'b0;
        sym_cell[i] = '0;
      end
      cells_used = 0;
      open_valid = 1'b0;
      open_letter = '0;
      open_lower = 1'b0;
      errors = 0;
    endfunction

    function void set_merged(logic idx, logic [4:0] val);
      if (idx == pfc_pkg::CFG_MERGED_FIRST) merged_a = val;
      else merged_b = val;
    endfunction

    function int pending();
      return ciphertext_q.size();
    endfunction

    function logic [4:0] symbol_of(logic [4:0] letter);
      return (letter == merged_a || letter == merged_b) ? pfc_pkg::SHARED_SYM : letter;
    endfunction

    function void add_symbol(logic [4:0] s);
      if (sym_in_table[s] || cells_used >= pfc_pkg::CELLS) return;
      cell_sym[cells_used] = s;
      sym_cell[s] = 5'(cells_used);
      sym_in_table[s] = 1'b1;
      cells_used++;
    endfunction

    function logic [7:0] glyph(logic [4:0] s, bit lower);
      if (s >= pfc_pkg::SHARED_SYM) return pfc_pkg::CHAR_STAR;
      return (lower ? pfc_pkg::CHAR_LOWER_A : pfc_pkg::CHAR_UPPER_A) + {3'b000, s};
    endfunction

    function void push_char(logic [7:0] c);
      cipher_char_t e;
      e.ch = c;
      e.last = 1'b0;
      step_q.push_back(e);
    endfunction

    function void encrypt_pair(logic [4:0] l1, bit lo1, logic [4:0] l2, bit lo2);
      logic [4:0] s1, s2, o1, o2;
      int p1, p2, r1, c1, r2, c2, q1, q2;
      s1 = symbol_of(l1);
      s2 = symbol_of(l2);
      o1 = s1;
      o2 = s2;
      if (sym_in_table[s1] && sym_in_table[s2] && sym_cell[s1] != sym_cell[s2]) begin
        p1 = int'(sym_cell[s1]) % pfc_pkg::CELLS;
        p2 = int'(sym_cell[s2]) % pfc_pkg::CELLS;
        r1 = p1 / GRID_SIDE;
        c1 = p1 % GRID_SIDE;
        r2 = p2 / GRID_SIDE;
        c2 = p2 % GRID_SIDE;
        if (r1 == r2) begin
          q1 = r1 * GRID_SIDE + (c1 + 1) % GRID_SIDE;
          q2 = r2 * GRID_SIDE + (c2 + 1) % GRID_SIDE;
        end else if (c1 == c2) begin
          q1 = ((r1 + 1) % GRID_SIDE) * GRID_SIDE + c1;
          q2 = ((r2 + 1) % GRID_SIDE) * GRID_SIDE + c2;
        end else begin
          q1 = r1 * GRID_SIDE + c2;
          q2 = r2 * GRID_SIDE + c1;
        end
        o1 = cell_sym[q1];
        o2 = cell_sym[q2];
      end
      push_char(glyph(o1, lo1));
      push_char(glyph(o2, lo2));
    endfunction

    function void flush_open();
      if (open_valid) begin
        encrypt_pair(open_letter, open_lower, pfc_pkg::PAD_LETTER, 1'b0);
        open_valid = 1'b0;
        open_letter = '0;
        open_lower = 1'b0;
      end
    endfunction

    function void encrypt_item(logic [1:0] mode, logic [7:0] ch);
      logic [4:0]   letter;
      bit           lower;
      bit           is_letter;
      cipher_char_t e;
      step_q.delete();
      letter = '0;
      lower = 1'b0;
      is_letter = 1'b0;
      if (ch >= pfc_pkg::CHAR_UPPER_A && ch <= pfc_pkg::CHAR_UPPER_Z) begin
        letter = 5'(ch - pfc_pkg::CHAR_UPPER_A);
        is_letter = 1'b1;
      end else if (ch >= pfc_pkg::CHAR_LOWER_A && ch <= pfc_pkg::CHAR_LOWER_Z) begin
        letter = 5'(ch - pfc_pkg::CHAR_LOWER_A);
        lower = 1'b1;
        is_letter = 1'b1;
      end
      case (mode)
        pfc_pkg::MODE_KEY: begin
          if (is_letter) add_symbol(symbol_of(letter));
        end
        pfc_pkg::MODE_SEAL: begin
          for (int l = 0; l <= int'(pfc_pkg::LAST_LETTER); l++) begin
            add_symbol(symbol_of(5'(l)));
          end
        end
        pfc_pkg::MODE_TEXT: begin
          if (ch == pfc_pkg::CHAR_DOT) begin
            flush_open();
            push_char(pfc_pkg::CHAR_DOT);
          end else if (is_letter) begin
            if (!open_valid) begin
              if (symbol_of(letter) == pfc_pkg::SHARED_SYM) begin
                encrypt_pair(letter, lower, pfc_pkg::PAD_LETTER, 1'b0);
              end else begin
                open_valid = 1'b1;
                open_letter = letter;
                open_lower = lower;
              end
            end else if (letter == open_letter) begin
              encrypt_pair(open_letter, open_lower, pfc_pkg::PAD_LETTER, 1'b0);
              open_lower = lower;
            end else begin
              encrypt_pair(open_letter, open_lower, letter, lower);
              open_valid = 1'b0;
              open_letter = '0;
              open_lower = 1'b0;
            end
          end
        end
        default: flush_open();
      endcase
      if (step_q.size() > 0) begin
        e = step_q.pop_back();
        e.last = 1'b1;
        step_q.push_back(e);
      end
      foreach (step_q[i]) ciphertext_q.push_back(step_q[i]);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_cipher_char(logic [7:0] ch, logic last);
      cipher_char_t e;
      if (ciphertext_q.size() == 0) begin
        report($sformatf("unexpected transaction char_out=%02h last=%0b", ch, last));
        return;
      end
      e = ciphertext_q.pop_front();
      if (ch !== e.ch || last !== e.last)
        report($sformatf("char_out=%02h last=%0b, expected char_out=%02h last=%0b",
                         ch, last, e.ch, e.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [4:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  logic [7:0] in_char_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char_out;
  logic       out_last;

  cipher_sb sb;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;
  int       quiet_cycles;

  playfair_digraph_cipher_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_char_in   (in_char_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.encrypt_item(in_mode, in_char_in);
      if (out_valid && out_ready) sb.check_cipher_char(out_char_out, out_last);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_merged(input logic [4:0] first_l, input logic [4:0] second_l);
    cfg_wr_en <= 1'b1;
    cfg_index <= pfc_pkg::CFG_MERGED_FIRST;
    cfg_data  <= first_l;
    @(posedge clk);
    sb.set_merged(pfc_pkg::CFG_MERGED_FIRST, first_l);
    cfg_index <= pfc_pkg::CFG_MERGED_SECOND;
    cfg_data  <= second_l;
    @(posedge clk);
    sb.set_merged(pfc_pkg::CFG_MERGED_SECOND, second_l);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_text(input int count);
    int         done;
    int         pick;
    int         l;
    int         prev_l;
    int         which;
    bit         counts;
    logic [1:0] m;
    logic [7:0] c;
    done = 0;
    prev_l = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      counts = 1'b1;
      m = pfc_pkg::MODE_TEXT;
      if (pick < 70) begin
        if ($urandom_range(0, 5) == 0) begin
          l = prev_l;
        end else if ($urandom_range(0, 4) == 0) begin
          which = $urandom_range(0, 2);
          l = (which == 0) ? int'(sb.merged_a)
            : (which == 1) ? int'(sb.merged_b)
                           : int'(pfc_pkg::PAD_LETTER);
          if (l > int'(pfc_pkg::LAST_LETTER)) l = int'(pfc_pkg::PAD_LETTER);
        end else begin
          l = $urandom_range(0, 25);
        end
        prev_l = l;
        c = 8'(($urandom_range(0, 1) ? pfc_pkg::CHAR_LOWER_A : pfc_pkg::CHAR_UPPER_A) + l);
      end else if (pick < 78) begin
        c = pfc_pkg::CHAR_DOT;
      end else if (pick < 84) begin
        m = pfc_pkg::MODE_END;
        c = 8'($urandom);
      end else if (pick < 92) begin
        c = 8'($urandom_range(0, 255));
        counts = (c == pfc_pkg::CHAR_DOT) ||
                 (c >= pfc_pkg::CHAR_UPPER_A && c <= pfc_pkg::CHAR_UPPER_Z) ||
                 (c >= pfc_pkg::CHAR_LOWER_A && c <= pfc_pkg::CHAR_LOWER_Z);
      end else begin
        m = $urandom_range(0, 1) ? pfc_pkg::MODE_KEY : pfc_pkg::MODE_SEAL;
        c = 8'($urandom);
        counts = 1'b0;
      end
      send_item(m, c);
      if (counts) done++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = pfc_pkg::CFG_MERGED_FIRST;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = pfc_pkg::MODE_KEY;
    in_char_in = '0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle_pct = 38;
    recv_idle_pct = 80;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: pairs pass through
    send_item(pfc_pkg::MODE_TEXT, "A");
    send_item(pfc_pkg::MODE_TEXT, "b");
    send_item(pfc_pkg::MODE_END, 8'h00);
    send_item(pfc_pkg::MODE_TEXT, "z");
    // key with case folding, repeats, non-letters
    send_item(pfc_pkg::MODE_KEY, "P");
    send_item(pfc_pkg::MODE_KEY, "l");
    send_item(pfc_pkg::MODE_KEY, "!");
    send_item(pfc_pkg::MODE_KEY, "a");
    send_item(pfc_pkg::MODE_KEY, "Q");
    send_item(pfc_pkg::MODE_KEY, 8'hFF);
    send_item(pfc_pkg::MODE_KEY, "z");
    send_item(pfc_pkg::MODE_KEY, "E");
    send_item(pfc_pkg::MODE_SEAL, 8'h00);
    send_item(pfc_pkg::MODE_KEY, "k");
    send_item(pfc_pkg::MODE_TEXT, "h");
    send_item(pfc_pkg::MODE_TEXT, "h");
    send_item(pfc_pkg::MODE_TEXT, ".");
    send_item(pfc_pkg::MODE_TEXT, "Z");
    send_item(pfc_pkg::MODE_TEXT, "x");
    send_item(pfc_pkg::MODE_TEXT, "x");
    send_item(pfc_pkg::MODE_END, 8'hFF);
    send_item(pfc_pkg::MODE_TEXT, ".");
    send_item(pfc_pkg::MODE_TEXT, "M");
    send_item(pfc_pkg::MODE_TEXT, "o");
    send_item(pfc_pkg::MODE_TEXT, "A");
    drain();
    // open letter becomes shared: same-cell pair
    set_merged(5'd0, 5'd16);
    send_item(pfc_pkg::MODE_TEXT, "q");
    drain();
    set_merged(pfc_pkg::PAD_LETTER, pfc_pkg::PAD_LETTER);
    send_item(pfc_pkg::MODE_TEXT, "x");
    send_item(pfc_pkg::MODE_TEXT, "b");
    send_item(pfc_pkg::MODE_END, 8'h00);
    drain();
    set_merged(5'd31, 5'd26);
    send_item(pfc_pkg::MODE_TEXT, "q");
    send_item(pfc_pkg::MODE_TEXT, "Z");
    drain();

    set_merged(5'd0, 5'd25);
    random_text(CHUNK_ITEMS);
    drain();
    set_merged(5'd25, 5'd0);
    random_text(CHUNK_ITEMS);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 38;
    set_merged(pfc_pkg::PAD_LETTER, 5'd7);
    random_text(CHUNK_ITEMS);
    drain();
    set_merged(5'd31, 5'd26);
    random_text(CHUNK_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_merged(5'd9, 5'd9);
    hold_cycles = 150;
    random_text(CHUNK_ITEMS);
    drain();
    set_merged(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    random_text(CHUNK_ITEMS);
    drain();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
